// ===== hdl/aes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 encryption package
// Beat types, register indexes, the S-box, round constants and the
// byte-level round functions shared by the key schedule and the round stages.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int NUM_ROUNDS  = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int ROUND_CNT_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } plain_t;

    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } cipher_t;

    typedef logic [127:0] block_t;

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] RCON [0:NUM_ROUNDS-1] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    // byte 0 sits in the top bits of the block
    function automatic logic [7:0] get_byte(input block_t s, input int idx);
        return s[127 - 8*idx -: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic block_t sub_shift(input block_t s);
        block_t t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8*(4*c + r) -: 8] = SBOX[get_byte(s, 4*((c + r) & 3) + r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t t);
        block_t     m;
        logic [7:0] a0;
        logic [7:0] a1;
        logic [7:0] a2;
        logic [7:0] a3;
        logic [7:0] all_x;
        for (int c = 0; c < 4; c++) begin
            a0    = get_byte(t, 4*c);
            a1    = get_byte(t, 4*c + 1);
            a2    = get_byte(t, 4*c + 2);
            a3    = get_byte(t, 4*c + 3);
            all_x = a0 ^ a1 ^ a2 ^ a3;
            m[127 - 8*(4*c)     -: 8] = a0 ^ all_x ^ xtime(a0 ^ a1);
            m[127 - 8*(4*c + 1) -: 8] = a1 ^ all_x ^ xtime(a1 ^ a2);
            m[127 - 8*(4*c + 2) -: 8] = a2 ^ all_x ^ xtime(a2 ^ a3);
            m[127 - 8*(4*c + 3) -: 8] = a3 ^ all_x ^ xtime(a3 ^ a0);
        end
        return m;
    endfunction

    function automatic block_t key_step(input block_t k, input logic [7:0] rc);
        block_t n;
        n[127:120] = get_byte(k, 0) ^ SBOX[get_byte(k, 13)] ^ rc;
        n[119:112] = get_byte(k, 1) ^ SBOX[get_byte(k, 14)];
        n[111:104] = get_byte(k, 2) ^ SBOX[get_byte(k, 15)];
        n[103:96]  = get_byte(k, 3) ^ SBOX[get_byte(k, 12)];
        n[95:64]   = k[95:64] ^ n[127:96];
        n[63:32]   = k[63:32] ^ n[95:64];
        n[31:0]    = k[31:0]  ^ n[63:32];
        return n;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/aes128_block_encrypt.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 block encryption engine
// Encrypts one 128-bit block per beat under the key in the key registers.
//
// Usage:
//   plain  channel: plain_valid / plain_stall, payload plain (plaintext).
//   cipher channel: cipher_valid / cipher_stall, payload cipher.
//   cfg port: cfg_write with cfg_index 0 (key high) or 1 (key low).
//   An accepted plaintext beat passes one key-add stage and ten round
//   stages to its cipher beat. Throughput is one block per cycle while
//   plain_stall is low; each stage holds one round of the cipher.
//   The key schedule derives one round key per cycle, so after reset and
//   after each key write plain_stall stays high until all ten are in place.
//   Reset clears the key to zero and empties the pipeline. When the
//   receiver stalls with the output stage full, the whole pipeline holds
//   and plain_stall rises; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module aes128_block_encrypt
    import aes_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   plain_valid,
    output logic                        plain_stall,
    input  wire plain_t                 plain,
    output logic                        cipher_valid,
    input  wire logic                   cipher_stall,
    output cipher_t                     cipher,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    block_t                      key0;
    logic [NUM_ROUNDS:1][127:0]  round_keys;
    logic                        key_busy;
    logic                        advance;
    logic                        accept;

    logic                        valid0_reg;
    block_t                      state0_reg;

    logic [NUM_ROUNDS:0]         stage_valid;
    block_t                      stage_state [0:NUM_ROUNDS];

    aes_key_expand u_key_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .key0       (key0),
        .round_keys (round_keys),
        .busy       (key_busy)
    );

    // the whole pipeline moves unless a finished block is held at the output
    assign advance     = !stage_valid[NUM_ROUNDS] || !cipher_stall;
    assign plain_stall = !advance || key_busy;
    assign accept      = plain_valid && !plain_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state0_reg <= block_t'(plain) ^ key0;
        end
    end

    assign stage_valid[0] = valid0_reg;
    assign stage_state[0] = state0_reg;

    for (genvar i = 1; i <= NUM_ROUNDS; i++)
    begin : g_round
        aes_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .mix_en    (i != NUM_ROUNDS),
            .valid_in  (stage_valid[i-1]),
            .state_in  (stage_state[i-1]),
            .round_key (round_keys[i]),
            .valid_out (stage_valid[i]),
            .state_out (stage_state[i])
        );
    end

    assign cipher_valid = stage_valid[NUM_ROUNDS];
    assign cipher       = cipher_t'(stage_state[NUM_ROUNDS]);

endmodule
`default_nettype wire

// ===== hdl/aes_key_expand.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128 key schedule
// Holds the key registers and derives one round key per cycle after reset
// and after every key write; busy stays high until all ten are in place.
// ----------------------------------------------------------------------------
module aes_key_expand
    import aes_pkg::*;
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [CFG_INDEX_W-1:0]                cfg_index,
    input  wire logic [CFG_DATA_W-1:0]                 cfg_data,
    output block_t                                     key0,
    output logic [NUM_ROUNDS:1][127:0]                 round_keys,
    output logic                                       busy
);

    logic [63:0]            key_high_reg;
    logic [63:0]            key_low_reg;
    logic                   busy_reg;
    logic [ROUND_CNT_W-1:0] cnt_reg;
    block_t                 work_reg;
    logic [NUM_ROUNDS:1][127:0] rk_reg;

    block_t                 src;
    block_t                 work_next;

    assign key0       = {key_high_reg, key_low_reg};
    assign round_keys = rk_reg;
    assign busy       = busy_reg;

    // the first step starts from the key itself
    assign src       = (cnt_reg == ROUND_CNT_W'(1)) ? key0 : work_reg;
    assign work_next = key_step(src, RCON[cnt_reg - ROUND_CNT_W'(1)]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            busy_reg     <= 1'b1;
            cnt_reg      <= ROUND_CNT_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default:      ;
            endcase
            // restart the schedule on the new key
            busy_reg <= 1'b1;
            cnt_reg  <= ROUND_CNT_W'(1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == ROUND_CNT_W'(NUM_ROUNDS))
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg + ROUND_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_write)
        begin
            work_reg <= work_next;
            for (int i = 1; i <= NUM_ROUNDS; i++)
            begin
                if (cnt_reg == ROUND_CNT_W'(i))
                begin
                    rk_reg[i] <= work_next;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== hdl/aes_round.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES round stage
// One registered round: SubBytes, ShiftRows, optional MixColumns and
// AddRoundKey, with a valid bit that travels alongside the state.
// ----------------------------------------------------------------------------
module aes_round
    import aes_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   advance,
    input  wire logic   mix_en,
    input  wire logic   valid_in,
    input  wire block_t state_in,
    input  wire block_t round_key,
    output logic        valid_out,
    output block_t      state_out
);

    logic   valid_reg;
    block_t state_reg;
    block_t shifted;
    block_t state_next;

    assign shifted    = sub_shift(state_in);
    assign state_next = (mix_en ? mix_columns(shifted) : shifted) ^ round_key;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
        end
    end

    assign valid_out = valid_reg;
    assign state_out = state_reg;

endmodule
`default_nettype wire
